// ===== hw/rtl/prhd_pkg.sv =====
// Package for the parallel ROM hex dump sequencer.
// Widths, phase codes, ASCII constants, word and state types, hex digit lookup.
// No dependencies.
`default_nettype none

package prhd_pkg;

	localparam int ADDR_BITS = 19;
	// address times four plus phase, one extra bit for the terminal count
	localparam int CNT_W     = ADDR_BITS + 3;
	localparam int DONE_BIT  = ADDR_BITS + 2;

	localparam logic [3:0] LINE_LAST = 4'hf;
	localparam logic [3:0] LINE_FIRST = 4'h0;

	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NONE  = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LOWA  = 8'h61;

	typedef enum logic [1:0] {
		PH_ADDR = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2,
		PH_SEP  = 2'd3
	} phase_t;

	typedef struct packed {
		logic       tx_ready;
		logic [7:0] data_in;
	} in_word_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] rom_addr;
		logic                 oe_n;
		logic                 tx_valid;
		logic [7:0]           tx_char;
		logic                 done_res;
	} out_word_t;

	typedef struct packed {
		logic [CNT_W-1:0] step_cnt;
		logic [7:0]       byte_val;
		logic             oe_on;
	} seq_state_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] ch;
		if (nib < 4'd10) begin
			ch = CH_ZERO + {4'd0, nib};
		end else begin
			ch = CH_LOWA + {4'd0, nib} - 8'd10;
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/prhd_if.sv =====
// Valid/ready channel interfaces for the hex dump sequencer.
// Depends on prhd_pkg for the address width.
`default_nettype none

interface prhd_in_if;
	import prhd_pkg::*;

	logic       valid;
	logic       ready;
	logic       tx_ready;
	logic [7:0] data_in;

	modport source (output valid, output tx_ready, output data_in, input ready);
	modport sink   (input valid, input tx_ready, input data_in, output ready);
endinterface

interface prhd_out_if;
	import prhd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] rom_addr;
	logic                 oe_n;
	logic                 tx_valid;
	logic [7:0]           tx_char;
	logic                 done_res;

	modport source (output valid, output rom_addr, output oe_n, output tx_valid,
		output tx_char, output done_res, input ready);
	modport sink   (input valid, input rom_addr, input oe_n, input tx_valid,
		input tx_char, input done_res, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/prhd_step.sv =====
// One tick of the dump sequencer: next state and result word from the
// current state and the registered input word. Depends on prhd_pkg.
`default_nettype none

module prhd_step (
	input  prhd_pkg::seq_state_t st,
	input  prhd_pkg::in_word_t   din,
	output prhd_pkg::seq_state_t st_nx,
	output prhd_pkg::out_word_t  res
);
	import prhd_pkg::*;

	logic [ADDR_BITS-1:0] addr;
	phase_t               phase;
	logic                 line_start;
	logic                 line_end;
	logic                 advance;
	logic                 send;
	logic [7:0]           ch;
	logic [7:0]           byte_cur;
	logic                 oe_nx;
	logic                 done;

	assign addr       = st.step_cnt[DONE_BIT-1:2];
	assign phase      = phase_t'(st.step_cnt[1:0]);
	assign done       = st.step_cnt[DONE_BIT];
	assign line_start = (addr[3:0] == LINE_FIRST);
	assign line_end   = (addr[3:0] == LINE_LAST);

	always_comb begin
		advance  = 1'b0;
		send     = 1'b0;
		ch       = CH_NONE;
		oe_nx    = st.oe_on;
		byte_cur = st.byte_val;
		if (done) begin
			oe_nx = 1'b0;
		end else begin
			case (phase)
				PH_ADDR: begin
					// newline goes out first at each line start
					if (!line_start || din.tx_ready) begin
						oe_nx   = 1'b1;
						advance = 1'b1;
						send    = line_start;
						ch      = line_start ? CH_LF : CH_NONE;
					end
				end
				PH_HIGH, PH_LOW, PH_SEP: begin
					// latch on the first try only, while OE is still on
					if (phase == PH_HIGH && st.oe_on) begin
						byte_cur = din.data_in;
						oe_nx    = 1'b0;
					end
					if (din.tx_ready) begin
						send    = 1'b1;
						advance = 1'b1;
						case (phase)
							PH_HIGH: ch = hex_char(byte_cur[7:4]);
							PH_LOW:  ch = hex_char(byte_cur[3:0]);
							PH_SEP:  ch = line_end ? CH_CR : CH_SPACE;
							default: ch = CH_NONE;
						endcase
					end
				end
				default: begin
					advance = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		st_nx.step_cnt = advance ? st.step_cnt + CNT_W'(1) : st.step_cnt;
		st_nx.byte_val = byte_cur;
		st_nx.oe_on    = oe_nx;

		res.rom_addr = done ? {ADDR_BITS{1'b1}} : addr;
		res.oe_n     = ~oe_nx;
		res.tx_valid = send;
		res.tx_char  = ch;
		res.done_res = st_nx.step_cnt[DONE_BIT];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/parallel_rom_hex_dump_sequencer_unit.sv =====
// Parallel ROM hex dump sequencer, top level.
// Input register, sequencer state, prhd_step logic and result register.
// Depends on prhd_pkg, prhd_if and prhd_step.
//
// Usage:
//   item   : one word per tick: tx_ready (transmitter can take a character)
//            and data_in (byte on the memory data pins).
//   result : one word per item: rom_addr, oe_n, tx_valid, tx_char, done_res,
//            giving the pin and transmitter drive after that tick.
//   Each item first sits in the input register, then the result register
//   loads its result word, which holds there until it is taken. One item is
//   taken every cycle while the receiver is not stalling; the address/phase
//   counter update is a single increment.
//   Reset (arst_n low) clears the counter, latched byte and output enable,
//   and empties both registers. The dump starts at address 0 and, after the
//   last address, every further word reports done with output enable off.
//   When the receiver stalls the result word holds and the input register
//   fills; item.ready falls only when both are full, so no word is lost.
`default_nettype none

module parallel_rom_hex_dump_sequencer_unit (
	input  wire        clk,
	input  wire        arst_n,
	prhd_in_if.sink    item,
	prhd_out_if.source result
);
	import prhd_pkg::*;

	logic       valid_s1;
	in_word_t   in_s1;
	seq_state_t st_q;
	seq_state_t st_nx;
	out_word_t  res_nx;
	out_word_t  out_q;
	logic       out_valid_q;
	logic       out_free;
	logic       adv_s1;

	assign out_free   = !out_valid_q || result.ready;
	assign adv_s1     = valid_s1 && out_free;
	assign item.ready = !valid_s1 || out_free;

	prhd_step u_step (
		.st    (st_q),
		.din   (in_s1),
		.st_nx (st_nx),
		.res   (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			in_s1.tx_ready <= item.tx_ready;
			in_s1.data_in  <= item.data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			st_q        <= st_nx;
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q <= res_nx;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.rom_addr = out_q.rom_addr;
	assign result.oe_n     = out_q.oe_n;
	assign result.tx_valid = out_q.tx_valid;
	assign result.tx_char  = out_q.tx_char;
	assign result.done_res = out_q.done_res;

	// once finished the counter never moves again
	a_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.step_cnt[DONE_BIT] |=> st_q.step_cnt[DONE_BIT])
		else $error("sequencer left the done state");

	// finished sequencer keeps the memory disabled; only the closing CR goes out with done
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.done_res)
		|-> (result.oe_n && (!result.tx_valid || result.tx_char == CH_CR)))
		else $error("activity after done");

	// no character code without a send
	a_char_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.tx_valid) |-> (result.tx_char == CH_NONE))
		else $error("character driven without tx_valid");

	// a processed high-digit tick always leaves output enable released
	a_oe_release: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !st_q.step_cnt[DONE_BIT] && st_q.step_cnt[1:0] == PH_HIGH)
		|=> !st_q.oe_on)
		else $error("output enable not released after latch");

endmodule

`default_nettype wire

// ===== verif/prhd_dump_check_pkg.sv =====
// Scoreboard for the hex dump sequencer: tick-by-tick prediction of the pin and
// transmitter drive, and the queue of words still owed by the block.
// Depends on prhd_pkg for widths, phase codes, ASCII codes and word types.
package prhd_dump_check_pkg;
	import prhd_pkg::*;

	localparam logic [CNT_W-1:0] DUMP_END = {1'b1, {(ADDR_BITS + 2){1'b0}}};
	localparam logic [127:0] GLYPHS = "0123456789abcdef";

	function automatic logic [7:0] nibble_glyph(input logic [3:0] nib);
		return GLYPHS[8 * (15 - int'(nib)) +: 8];
	endfunction

	class dump_tracker;
		out_word_t        owed_drive[$];
		logic [CNT_W-1:0] step_cnt;
		logic [7:0]       held_byte;
		bit               oe_on;
		int unsigned      errors;
		int unsigned      words_checked;

		function new();
			step_cnt = '0;
			held_byte = '0;
			oe_on = 1'b0;
			errors = 0;
			words_checked = 0;
		endfunction

		function void report(input string msg);
			errors++;
			$display("[%0t] %s", $time, msg);
		endfunction

		// advance the sequencer by one tick and return the drive it leaves behind
		function out_word_t next_drive(input in_word_t w);
			out_word_t            o;
			logic [ADDR_BITS-1:0] addr;
			phase_t               ph;
			logic                 send;
			logic                 adv;
			logic [7:0]           ch;
			send = 1'b0;
			adv = 1'b0;
			ch = CH_NONE;
			if (step_cnt >= DUMP_END) begin
				step_cnt = DUMP_END;
				oe_on = 1'b0;
				addr = '1;
			end else begin
				addr = step_cnt[ADDR_BITS+1:2];
				ph = phase_t'(step_cnt[1:0]);
				if (ph == PH_ADDR) begin
					if (addr[3:0] == LINE_FIRST) begin
						// new line: LF goes out first, so a busy transmitter holds oe off
						if (w.tx_ready) begin
							send = 1'b1;
							ch = CH_LF;
							oe_on = 1'b1;
							adv = 1'b1;
						end
					end else begin
						oe_on = 1'b1;
						adv = 1'b1;
					end
				end else begin
					// byte taken only on the first high-digit try
					if (ph == PH_HIGH && oe_on) begin
						held_byte = w.data_in;
						oe_on = 1'b0;
					end
					if (w.tx_ready) begin
						send = 1'b1;
						adv = 1'b1;
						case (ph)
							PH_SEP:  ch = (addr[3:0] == LINE_LAST) ? CH_CR : CH_SPACE;
							PH_HIGH: ch = nibble_glyph(held_byte[7:4]);
							default: ch = nibble_glyph(held_byte[3:0]);
						endcase
					end
				end
				if (adv) begin
					step_cnt = step_cnt + 1'b1;
				end
			end
			o.rom_addr = addr;
			o.oe_n = !oe_on;
			o.tx_valid = send;
			o.tx_char = ch;
			o.done_res = (step_cnt >= DUMP_END);
			return o;
		endfunction

		function void note_tick(input in_word_t w);
			owed_drive.push_back(next_drive(w));
		endfunction

		function void check_drive(input out_word_t got);
			out_word_t want;
			if (owed_drive.size() == 0) begin
				report("result word arrived with nothing owed");
				return;
			end
			want = owed_drive.pop_front();
			if (got.rom_addr !== want.rom_addr)
				report($sformatf("word %0d rom_addr: got %h want %h",
					words_checked, got.rom_addr, want.rom_addr));
			if (got.oe_n !== want.oe_n)
				report($sformatf("word %0d oe_n: got %b want %b",
					words_checked, got.oe_n, want.oe_n));
			if (got.tx_valid !== want.tx_valid)
				report($sformatf("word %0d tx_valid: got %b want %b",
					words_checked, got.tx_valid, want.tx_valid));
			if (got.tx_char !== want.tx_char)
				report($sformatf("word %0d tx_char: got %h want %h",
					words_checked, got.tx_char, want.tx_char));
			if (got.done_res !== want.done_res)
				report($sformatf("word %0d done_res: got %b want %b",
					words_checked, got.done_res, want.done_res));
			words_checked++;
		endfunction
	endclass

endpackage

// ===== verif/tb.sv =====
// Top-level testbench for parallel_rom_hex_dump_sequencer_unit.
// Drives directed then random ticks with random gaps and stalls, checks each result word.
// Depends on prhd_pkg, prhd_if, prhd_dump_check_pkg and the RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import prhd_pkg::*;
	import prhd_dump_check_pkg::*;

	localparam int RANDOM_TICKS = 1750;
	localparam int RUN_LIMIT    = 400000;
	localparam int HOLD_CYCLES  = 80;

	logic clk;
	logic arst_n;
	bit   quiet;
	bit   hold_req;
	int unsigned cycle_count;

	dump_tracker board = new();

	prhd_in_if  item_ch ();
	prhd_out_if result_ch ();

	parallel_rom_hex_dump_sequencer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			board.check_drive(out_word_t'{
				rom_addr: result_ch.rom_addr,
				oe_n:     result_ch.oe_n,
				tx_valid: result_ch.tx_valid,
				tx_char:  result_ch.tx_char,
				done_res: result_ch.done_res
			});
		end
	end

	// receiver: random stalls, plus one long hold-off to back the block up
	initial begin
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				result_ch.ready <= quiet || ($urandom_range(99) >= 17);
			end
		end
	end

	task automatic send_tick(input logic rdy, input logic [7:0] data);
		item_ch.valid <= 1'b1;
		item_ch.tx_ready <= rdy;
		item_ch.data_in <= data;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		board.note_tick(in_word_t'{tx_ready: rdy, data_in: data});
		@(negedge clk);
		// each cycle idles with the same odds, so gaps stay near 17 in a hundred
		while (!quiet && $urandom_range(99) < 17) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
	endtask

	in_word_t opening[$] = '{
		'{1'b0, 8'h00},	// line start, transmitter busy
		'{1'b1, 8'h5a},	// LF
		'{1'b0, 8'hff},	// byte taken here
		'{1'b0, 8'h00},	// retry keeps ff
		'{1'b1, 8'h12},
		'{1'b0, 8'h34},
		'{1'b1, 8'h00},
		'{1'b0, 8'h00},
		'{1'b1, 8'hff},
		'{1'b0, 8'hff},	// mid-line address phase ignores busy
		'{1'b1, 8'h00},
		'{1'b1, 8'hff},
		'{1'b1, 8'h00},
		'{1'b1, 8'h00},
		'{1'b1, 8'ha5},
		'{1'b1, 8'h00},
		'{1'b1, 8'h00},
		'{1'b1, 8'h00},
		'{1'b1, 8'h9c},
		'{1'b1, 8'h00},
		'{1'b0, 8'h00},
		'{1'b1, 8'h00}
	};

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.tx_ready = 1'b0;
		item_ch.data_in = 8'h00;
		quiet = 1'b0;
		hold_req = 1'b0;
		cycle_count = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (opening[i]) begin
			send_tick(opening[i].tx_ready, opening[i].data_in);
		end
		for (int i = 0; i < RANDOM_TICKS; i++) begin
			quiet = (i >= 300 && i < 700);
			if (i == 1000) begin
				hold_req = 1'b1;
			end
			send_tick($urandom_range(99) < 75, 8'($urandom_range(255)));
		end
		item_ch.valid <= 1'b0;
		while (board.owed_drive.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.owed_drive.size() != 0) begin
			board.report("expected words left over at the end");
		end
		if (board.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/prhd_pkg.sv
hw/rtl/prhd_if.sv
hw/rtl/prhd_step.sv
hw/rtl/parallel_rom_hex_dump_sequencer_unit.sv
verif/prhd_dump_check_pkg.sv
verif/tb.sv
